### sv/sspp_pkg.sv
`default_nettype none

package sspp_pkg;

  // Header byte that opens every status frame
  localparam logic [7:0] HDR_BYTE = 8'hFF;

  // Result kinds
  localparam logic [2:0] K_ID       = 3'd0;
  localparam logic [2:0] K_LEN      = 3'd1;
  localparam logic [2:0] K_ERR      = 3'd2;
  localparam logic [2:0] K_PARAM    = 3'd3;
  localparam logic [2:0] K_OK       = 3'd4;
  localparam logic [2:0] K_CSUM_BAD = 3'd5;
  localparam logic [2:0] K_BAD_HDR  = 3'd6;
  localparam logic [2:0] K_BAD_LEN  = 3'd7;

  // Frame walk, one-hot
  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_HDR2  = 7'b0000010,
    PH_ID    = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_ERR   = 7'b0010000,
    PH_PARAM = 7'b0100000,
    PH_CSUM  = 7'b1000000
  } phase_t;

  // Parser state carried from item to item
  typedef struct packed {
    phase_t     phase;
    logic [7:0] bytes_left;
    logic [7:0] running_sum;
    logic [7:0] param_count;
  } parse_state_t;

  // One result item, with a flag for whether the item gives one
  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [7:0] value;
    logic [7:0] param_index;
    logic       frame_end;
  } parse_res_t;

endpackage

`default_nettype wire

### sv/sspp_step.sv
`default_nettype none

module sspp_step
  import sspp_pkg::*;
(
  input  var parse_state_t st,
  input  wire logic [7:0]  rx_byte,
  output parse_state_t     st_next,
  output parse_res_t       res
);

  logic [7:0] expect_sum;
  logic [7:0] left_dec;

  assign expect_sum = ~st.running_sum;
  assign left_dec   = (st.bytes_left != 8'd0) ? (st.bytes_left - 8'd1) : st.bytes_left;

  // Next state and result for one received byte
  always_comb begin
    st_next = st;
    res     = '0;
    case (st.phase)
      PH_HDR2: begin
        if (rx_byte == HDR_BYTE) begin
          st_next.phase = PH_ID;
        end else begin
          st_next.phase = PH_IDLE;
          res.valid     = 1'b1;
          res.kind      = K_BAD_HDR;
          res.frame_end = 1'b1;
        end
      end
      PH_ID: begin
        st_next.running_sum = rx_byte;
        st_next.param_count = 8'd0;
        st_next.phase       = PH_LEN;
        res.valid           = 1'b1;
        res.kind            = K_ID;
        res.value           = rx_byte;
      end
      PH_LEN: begin
        if (rx_byte < 8'd2) begin
          st_next.phase = PH_IDLE;
          res.valid     = 1'b1;
          res.kind      = K_BAD_LEN;
          res.frame_end = 1'b1;
        end else begin
          st_next.running_sum = st.running_sum + rx_byte;
          st_next.bytes_left  = rx_byte - 8'd2;
          st_next.phase       = PH_ERR;
          res.valid           = 1'b1;
          res.kind            = K_LEN;
          res.value           = rx_byte;
        end
      end
      PH_ERR: begin
        st_next.running_sum = st.running_sum + rx_byte;
        st_next.phase       = (st.bytes_left == 8'd0) ? PH_CSUM : PH_PARAM;
        res.valid           = 1'b1;
        res.kind            = K_ERR;
        res.value           = rx_byte;
      end
      PH_PARAM: begin
        st_next.running_sum = st.running_sum + rx_byte;
        st_next.param_count = st.param_count + 8'd1;
        st_next.bytes_left  = left_dec;
        if (left_dec == 8'd0) begin
          st_next.phase = PH_CSUM;
        end
        res.valid       = 1'b1;
        res.kind        = K_PARAM;
        res.value       = rx_byte;
        res.param_index = st.param_count;
      end
      PH_CSUM: begin
        st_next.phase = PH_IDLE;
        res.valid     = 1'b1;
        res.kind      = (rx_byte == expect_sum) ? K_OK : K_CSUM_BAD;
        res.frame_end = 1'b1;
      end
      default: begin
        // idle: skip zeros, look for the first header byte
        st_next.phase = PH_IDLE;
        if (rx_byte == HDR_BYTE) begin
          st_next.phase = PH_HDR2;
        end else if (rx_byte != 8'd0) begin
          res.valid     = 1'b1;
          res.kind      = K_BAD_HDR;
          res.frame_end = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/servo_status_packet_parser.sv
`default_nettype none

// Status frame parser for a half-duplex serial servo bus.
// Input channel: in_valid / in_stall with rx_byte, one received byte per item.
// Output channel: out_valid / out_stall with kind, value, param_index and
// frame_end; each byte gives zero or one result item.
// Header bytes and idle zeros give no result; id, length, error byte and each
// parameter give one, and every frame closes with one verdict (frame_end=1):
// checksum ok, checksum bad, bad header or bad length.
// A byte is held in the input register and its result item, if any, in the
// result register. Throughput: one byte per cycle while in_stall is low.
// A byte that gives no result moves on even while the output is
// stalled; a byte that gives a result waits in the input register until the
// result register is free, and in_stall is held high for the next byte
// while it waits.
// Reset (rst, synchronous) empties both registers and returns the parser to
// idle, waiting for the first header byte.
module servo_status_packet_parser
  import sspp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      kind,
  output logic [7:0]      value,
  output logic [7:0]      param_index,
  output logic            frame_end
);

  logic         in_full;
  logic [7:0]   in_byte;
  parse_state_t st;
  parse_state_t st_next;
  parse_res_t   res;
  logic         out_free;
  logic         advance;

  sspp_step u_step (
    .st      (st),
    .rx_byte (in_byte),
    .st_next (st_next),
    .res     (res)
  );

  // Handshake between the two registers
  assign out_free = !out_valid || !out_stall;
  assign advance  = in_full && (!res.valid || out_free);
  assign in_stall = in_full && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= PH_IDLE;
      st.bytes_left  <= 8'd0;
      st.running_sum <= 8'd0;
      st.param_count <= 8'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      kind        <= res.kind;
      value       <= res.value;
      param_index <= res.param_index;
      frame_end   <= res.frame_end;
    end
  end

endmodule

`default_nettype wire
